>>> rtl/core/bptst_pkg.sv
// Package for the best priority tie set tracker.
// Holds the transaction payload types, command codes and status codes.
// Depends on nothing; imported by best_priority_tie_set_tracker.
package bptst_pkg;

  localparam int unsigned KEY_W = 40;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [3:0] {
    STAT_FIRST     = 4'd0,
    STAT_REPLACED  = 4'd1,
    STAT_APPENDED  = 4'd2,
    STAT_WORSE     = 4'd3,
    STAT_DUPLICATE = 4'd4,
    STAT_OVERFLOW  = 4'd5,
    STAT_RESET     = 4'd6,
    STAT_READ_OK   = 4'd7,
    STAT_READ_BAD  = 4'd8
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] symbol_handle;
    logic [15:0] scope_depth;
    logic [7:0]  visibility_rank;
    logic [15:0] search_order;
    logic [3:0]  read_index;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  candidate_count;
    logic        ambiguous;
    logic [31:0] read_handle;
  } out_t;

endpackage

>>> rtl/core/best_priority_tie_set_tracker.sv
// Best priority tie set tracker: keeps the best three-part priority seen so far
// and the distinct handles tied at it, in a one-port synchronous handle memory.
// Depends on bptst_pkg for the payload types and the command and status codes.
//
// Use: every input transaction carries an add, reset or read command and gives
// exactly one output transaction, in order. Both channels use valid/ready.
// The block works on one transaction at a time. Reset, worse, first and better
// adds and out-of-range reads finish in the execute state; an in-range read
// first waits for the registered memory read, and an add that ties the best
// priority first scans the held handles for a duplicate, reading one held
// handle per cycle through the single memory read port. Input ready rises at
// the edge that registers the result, so the next transaction is taken only
// after that. Input is taken while a result still waits in the output
// register; a stalled receiver only holds the next result at its last step,
// and no memory write happens until that result can be registered.
// Reset clears the best priority and the count at once; the handle memory has
// no clearing pass, since only slots below the count are ever read.
module best_priority_tie_set_tracker
  import bptst_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = 16,
  parameter int unsigned HANDLE_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_CANDIDATES);
  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN
  } state_e;

  // Control state.
  state_e             state_q, state_d;
  logic               best_valid_q, best_valid_d;
  logic [KEY_W-1:0]   best_key_q, best_key_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_addr_q, scan_addr_d;
  logic               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;
  in_t                item_q, item_d;

  // Handle memory with a registered read port.
  logic [HANDLE_BITS-1:0] held_mem_q [MAX_CANDIDATES];
  logic [HANDLE_BITS-1:0] rdata_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;

  // Helpers derived from the held transaction.
  logic [HANDLE_BITS+31:0] handle_ext;
  logic [HANDLE_BITS-1:0]  handle;
  logic [HANDLE_BITS+31:0] rdata_ext;
  logic [KEY_W-1:0]        key;
  logic [CMP_W-1:0]        rd_idx_ext;
  logic [CMP_W-1:0]        count_ext;
  logic [CNT_W+4:0]        count_out_ext;
  logic                    slot_free;
  logic                    scan_hit;
  logic                    finish;
  status_e                 res_status;
  logic [31:0]             res_handle;

  // The handle is kept to HANDLE_BITS: truncated when narrower, zero-extended
  // when wider. Read data goes back to the 32-bit port the same way.
  assign handle_ext = {{HANDLE_BITS{1'b0}}, item_q.symbol_handle};
  assign handle     = handle_ext[HANDLE_BITS-1:0];
  assign rdata_ext  = {32'd0, rdata_q};

  // Priority keys concatenated so a single compare orders them key by key.
  assign key = {item_q.scope_depth, item_q.visibility_rank, item_q.search_order};

  assign rd_idx_ext = CMP_W'(item_q.read_index);
  assign count_ext  = CMP_W'(count_q);

  // The output register can take a new result this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  // Data registered last cycle matches the offered handle.
  assign scan_hit = pend_q && (rdata_q == handle);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    best_valid_d = best_valid_q;
    best_key_d   = best_key_q;
    count_d      = count_q;
    scan_addr_d  = scan_addr_q;
    pend_d       = pend_q;
    item_d       = item_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_re       = 1'b0;
    mem_raddr    = scan_addr_q[IDX_W-1:0];
    finish       = 1'b0;
    res_status   = STAT_READ_BAD;
    res_handle   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (item_q.command)
          CMD_ADD: begin
            if (!best_valid_q || (key < best_key_q)) begin
              // First candidate, or a strictly better one: restart the set.
              if (slot_free) begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                best_valid_d = 1'b1;
                best_key_d   = key;
                count_d      = CNT_W'(1);
                finish       = 1'b1;
                res_status   = best_valid_q ? STAT_REPLACED : STAT_FIRST;
              end
            end else if (key > best_key_q) begin
              if (slot_free) begin
                finish     = 1'b1;
                res_status = STAT_WORSE;
              end
            end else begin
              scan_addr_d = '0;
              pend_d      = 1'b0;
              state_d     = S_SCAN;
            end
          end
          CMD_RESET: begin
            if (slot_free) begin
              best_valid_d = 1'b0;
              best_key_d   = '0;
              count_d      = '0;
              finish       = 1'b1;
              res_status   = STAT_RESET;
            end
          end
          default: begin
            // Read, with the unused command code treated the same way.
            if (rd_idx_ext < count_ext) begin
              mem_re    = 1'b1;
              mem_raddr = rd_idx_ext[IDX_W-1:0];
              state_d   = S_RD_WAIT;
            end else if (slot_free) begin
              finish     = 1'b1;
              res_status = STAT_READ_BAD;
            end
          end
        endcase
      end

      S_RD_WAIT: begin
        if (slot_free) begin
          finish     = 1'b1;
          res_status = STAT_READ_OK;
          res_handle = rdata_ext[31:0];
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          if (slot_free) begin
            finish     = 1'b1;
            res_status = STAT_DUPLICATE;
          end
        end else if (scan_addr_q < count_q) begin
          mem_re      = 1'b1;
          mem_raddr   = scan_addr_q[IDX_W-1:0];
          scan_addr_d = scan_addr_q + CNT_W'(1);
          pend_d      = 1'b1;
        end else if (slot_free) begin
          // Every held handle differs from the offered one.
          finish = 1'b1;
          if (count_q >= CNT_W'(MAX_CANDIDATES)) begin
            res_status = STAT_OVERFLOW;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = count_q[IDX_W-1:0];
            count_d    = count_q + CNT_W'(1);
            res_status = STAT_APPENDED;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      state_d = S_IDLE;
    end
  end

  assign count_out_ext = {5'd0, count_d};

  always_comb begin
    out_d.status          = res_status;
    out_d.candidate_count = count_out_ext[4:0];
    out_d.ambiguous       = (count_d > CNT_W'(1));
    out_d.read_handle     = res_handle;
    out_valid_d           = finish ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      best_valid_q <= 1'b0;
      best_key_q   <= '0;
      count_q      <= '0;
      scan_addr_q  <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      best_valid_q <= best_valid_d;
      best_key_q   <= best_key_d;
      count_q      <= count_d;
      scan_addr_q  <= scan_addr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (finish) begin
      out_q <= out_d;
    end
  end

  // Writes happen only when a transaction completes and reads only while one
  // is in progress, so a read never meets a write to the same slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      held_mem_q[mem_waddr] <= handle;
    end
    if (mem_re) begin
      rdata_q <= held_mem_q[mem_raddr];
    end
  end

  // A best priority exists exactly when the set holds at least one handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_valid_q == (count_q != '0))
    else $error("best priority and held count disagree");

  // The set never grows past its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CANDIDATES))
    else $error("held count beyond capacity");

  // The duplicate scan never runs past the held handles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_addr_q <= count_q))
    else $error("duplicate scan address beyond held count");

endmodule
